[design/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// cause on one edge implies effect on the next
`define ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cause |=> effect) \
        else $error(msg);

`endif

[design/wrt_pkg.sv]
// ----------------------------------------------------------------------------
// wrt_pkg
// shared constants, codes and structs of the worker resource table
// ----------------------------------------------------------------------------
package wrt_pkg;

    localparam int MAX_WORKERS     = 8;
    localparam int JOBS_PER_WORKER = 8;

    localparam int W_IDX  = 3;
    localparam int W_SLOT = (JOBS_PER_WORKER > 1) ? $clog2(JOBS_PER_WORKER) : 1;
    localparam int W_CNT  = 4;
    localparam int W_CPU  = 16;
    localparam int W_MEM  = 20;
    localparam int W_JOB  = 16;
    localparam int W_TIME = 32;

    localparam logic [W_TIME-1:0] TIMEOUT_RST = 32'd1000;

    typedef enum logic [2:0] {
        K_REGISTER  = 3'd0,
        K_HEARTBEAT = 3'd1,
        K_ALLOCATE  = 3'd2,
        K_RELEASE   = 3'd3,
        K_FIND_FIT  = 3'd4,
        K_RESERVE   = 3'd5,
        K_SWEEP     = 3'd6,
        K_GET       = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        C_NONE,
        C_REGISTER,
        C_BEAT,
        C_ALLOC,
        C_RELEASE,
        C_KILL
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_SWEEP
    } t_state;

    typedef struct packed {
        t_cell_op          op;
        logic [W_CPU-1:0]  cpu;
        logic [W_MEM-1:0]  mem;
        logic [W_JOB-1:0]  job;
        logic [W_TIME-1:0] now;
    } t_cell_cmd;

    typedef struct packed {
        logic                                   used;
        logic                                   alive;
        logic                                   stale;
        logic                                   dup;
        logic                                   has_free;
        logic [W_CPU-1:0]                       free_cpu;
        logic [W_MEM-1:0]                       free_mem;
        logic [W_CPU-1:0]                       cap_cpu;
        logic [W_MEM-1:0]                       cap_mem;
        logic [JOBS_PER_WORKER-1:0]             slot_valid;
        logic [JOBS_PER_WORKER-1:0][W_JOB-1:0]  slot_job;
    } t_cell_stat;

    typedef struct packed {
        logic             valid;
        logic             fit_mode;
        logic             exen;
        logic [W_IDX-1:0] exw;
        logic [W_CPU-1:0] req_cpu;
        logic [W_MEM-1:0] req_mem;
        logic             found;
        logic [W_IDX-1:0] best;
        logic [W_CPU-1:0] best_cpu;
    } t_token;

endpackage

[design/worker_resource_table.sv]
// ----------------------------------------------------------------------------
// worker_resource_table
// table of eight workers with capacity, heartbeat and job slots
// ----------------------------------------------------------------------------
// usage
//  - an item is taken when i_start is high and o_busy is low; i_kind selects
//    register, heartbeat, allocate, release, find fit, reservation target,
//    death sweep or get
//  - each result sits on the o_ ports for one cycle with o_strobe high;
//    o_last marks the final result of an item; the receiver cannot stall
//  - register, heartbeat, allocate, release and get: the result is registered
//    from the exec state; the next item may follow once o_busy is low again
//  - find fit and reservation target: a search token walks the row of
//    worker cells, one cell per cycle, and the result follows the last cell
//  - death sweep: stale flags of all cells are sampled at once, then the
//    dying workers are walked one slot per cycle and skipped workers one per
//    cycle
//  - i_cfg_we writes the heartbeat timeout; write only while idle, the block does not enforce it
//  - reset empties the table and sets the timeout to 1000 ticks
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module worker_resource_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [2:0]                  i_kind,
    input  logic [wrt_pkg::W_IDX-1:0]   i_target_worker,
    input  logic [wrt_pkg::W_CPU-1:0]   i_req_cpu,
    input  logic [wrt_pkg::W_MEM-1:0]   i_req_mem,
    input  logic [wrt_pkg::W_JOB-1:0]   i_job_tag,
    input  logic                        i_exclude_enable,
    input  logic [wrt_pkg::W_IDX-1:0]   i_exclude_worker,
    input  logic [wrt_pkg::W_TIME-1:0]  i_now_time,
    input  logic                        i_cfg_we,
    input  logic [wrt_pkg::W_TIME-1:0]  i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_ok,
    output logic [wrt_pkg::W_IDX-1:0]   o_result_worker,
    output logic                        o_orphan_valid,
    output logic [wrt_pkg::W_JOB-1:0]   o_orphan_job,
    output logic [wrt_pkg::W_CPU-1:0]   o_avail_cpu_out,
    output logic [wrt_pkg::W_MEM-1:0]   o_avail_mem_out,
    output logic [wrt_pkg::W_CPU-1:0]   o_total_cpu_out,
    output logic [wrt_pkg::W_MEM-1:0]   o_total_mem_out,
    output logic                        o_alive_out,
    output logic [wrt_pkg::W_CNT-1:0]   o_live_workers,
    output logic                        o_last
);
    import wrt_pkg::*;

    // latched item
    t_state            r_state, n_state;
    t_kind             r_kind;
    logic [W_IDX-1:0]  r_tw, r_exw;
    logic [W_CPU-1:0]  r_rc;
    logic [W_MEM-1:0]  r_rm;
    logic [W_JOB-1:0]  r_job;
    logic              r_exen;
    logic [W_TIME-1:0] r_now;
    logic [W_TIME-1:0] r_timeout;

    // table bookkeeping and sweep walk
    logic [W_CNT-1:0]       r_next, n_next;
    logic [MAX_WORKERS-1:0] r_dying, n_dying;
    logic [W_IDX-1:0]       r_w, n_w;
    logic [W_SLOT-1:0]      r_s, n_s;
    logic                   r_any, n_any;
    logic [W_CNT-1:0]       r_acnt, n_acnt;

    // result register
    logic              r_strobe;
    logic              r_ok, r_ov, r_alive_o, r_last;
    logic [W_IDX-1:0]  r_rw;
    logic [W_JOB-1:0]  r_oj;
    logic [W_CPU-1:0]  r_acpu, r_tcpu;
    logic [W_MEM-1:0]  r_amem, r_tmem;
    logic [W_CNT-1:0]  r_cnt;

    // emitted result this cycle
    logic              emit, e_ok, e_ov, e_get, e_last;
    logic [W_IDX-1:0]  e_rw;
    logic [W_JOB-1:0]  e_oj;
    logic [W_CNT-1:0]  e_cnt;

    // cell row
    t_cell_cmd              cmd;
    logic                   sel_en;
    logic [W_IDX-1:0]       sel_idx;
    logic [MAX_WORKERS-1:0] sel;
    t_cell_stat             stat [MAX_WORKERS];
    t_token                 tok  [MAX_WORKERS+1];
    t_token                 tok0;

    // helpers
    t_cell_stat             t_sel, c_sel;
    logic                   t_used, t_live;
    logic [W_CNT-1:0]       alive_cnt, after_cnt;
    logic [MAX_WORKERS-1:0] dying_now, above_w;
    logic                   more, cur_sv, higher;

    genvar g;
    generate
        for (g = 0; g < MAX_WORKERS; g++) begin : g_cell
            assign sel[g] = sel_en && (sel_idx == W_IDX'(g));
            wrt_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_idx     (W_IDX'(g)),
                .i_sel     (sel[g]),
                .i_cmd     (cmd),
                .i_timeout (r_timeout),
                .i_tok     (tok[g]),
                .o_tok     (tok[g+1]),
                .o_stat    (stat[g])
            );
        end
    endgenerate

    assign tok[0] = tok0;

    // target entry and sweep entry, alive counts, dying set
    always_comb begin
        t_sel     = '0;
        c_sel     = '0;
        alive_cnt = '0;
        after_cnt = '0;
        for (int i = 0; i < MAX_WORKERS; i++) begin
            if (r_tw == W_IDX'(i)) t_sel = stat[i];
            if (r_w == W_IDX'(i))  c_sel = stat[i];
            dying_now[i] = stat[i].used && stat[i].alive && stat[i].stale;
            above_w[i]   = W_IDX'(i) > r_w;
            alive_cnt    = alive_cnt + W_CNT'(stat[i].alive);
            after_cnt    = after_cnt + W_CNT'(stat[i].alive && !dying_now[i]);
        end
    end

    assign t_used = t_sel.used;
    assign t_live = t_sel.used && t_sel.alive;
    assign more   = |(r_dying & above_w);
    assign cur_sv = c_sel.slot_valid[r_s];

    always_comb begin
        higher = 1'b0;
        for (int j = 0; j < JOBS_PER_WORKER; j++) begin
            if ((W_SLOT'(j) > r_s) && c_sel.slot_valid[j]) higher = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_next  = r_next;
        n_dying = r_dying;
        n_w     = r_w;
        n_s     = r_s;
        n_any   = r_any;
        n_acnt  = r_acnt;
        emit    = 1'b0;
        e_ok    = 1'b0;
        e_ov    = 1'b0;
        e_get   = 1'b0;
        e_last  = 1'b1;
        e_rw    = '0;
        e_oj    = '0;
        e_cnt   = alive_cnt;
        cmd.op  = C_NONE;
        cmd.cpu = r_rc;
        cmd.mem = r_rm;
        cmd.job = r_job;
        cmd.now = r_now;
        sel_en  = 1'b0;
        sel_idx = r_tw;
        tok0          = '0;
        tok0.fit_mode = (r_kind == K_FIND_FIT);
        tok0.exen     = r_exen;
        tok0.exw      = r_exw;
        tok0.req_cpu  = r_rc;
        tok0.req_mem  = r_rm;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_kind)
                    K_REGISTER: begin
                        emit = 1'b1;
                        if (r_next < W_CNT'(MAX_WORKERS)) begin
                            cmd.op  = C_REGISTER;
                            sel_en  = 1'b1;
                            sel_idx = r_next[W_IDX-1:0];
                            n_next  = r_next + W_CNT'(1);
                            e_ok    = 1'b1;
                            e_rw    = r_next[W_IDX-1:0];
                            e_cnt   = alive_cnt + W_CNT'(1);
                        end
                    end
                    K_HEARTBEAT: begin
                        emit   = 1'b1;
                        e_ok   = t_live;
                        cmd.op = C_BEAT;
                        sel_en = t_live;
                    end
                    K_ALLOCATE: begin
                        emit = 1'b1;
                        e_ok = t_live && !t_sel.dup && (t_sel.free_cpu >= r_rc)
                            && (t_sel.free_mem >= r_rm) && t_sel.has_free;
                        cmd.op = C_ALLOC;
                        sel_en = e_ok;
                    end
                    K_RELEASE: begin
                        emit   = 1'b1;
                        e_ok   = t_live && t_sel.dup;
                        cmd.op = C_RELEASE;
                        sel_en = e_ok;
                    end
                    K_FIND_FIT, K_RESERVE: begin
                        tok0.valid = 1'b1;
                        n_state    = S_SEARCH;
                    end
                    K_SWEEP: begin
                        if (dying_now == '0) begin
                            emit = 1'b1;
                        end else begin
                            n_dying = dying_now;
                            n_acnt  = after_cnt;
                            n_w     = '0;
                            n_s     = '0;
                            n_any   = 1'b0;
                            n_state = S_SWEEP;
                        end
                    end
                    K_GET: begin
                        emit  = 1'b1;
                        e_ok  = t_used;
                        e_get = t_used;
                    end
                    default: ;
                endcase
            end
            S_SEARCH: begin
                if (tok[MAX_WORKERS].valid) begin
                    emit    = 1'b1;
                    e_ok    = tok[MAX_WORKERS].found;
                    e_rw    = tok[MAX_WORKERS].found ? tok[MAX_WORKERS].best : '0;
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                e_cnt   = r_acnt;
                e_rw    = r_w;
                sel_idx = r_w;
                if (!r_dying[r_w]) begin
                    // worker not in the dying set, step over it
                    n_w   = r_w + W_IDX'(1);
                    n_s   = '0;
                    n_any = 1'b0;
                end else begin
                    if (cur_sv) begin
                        emit   = 1'b1;
                        e_ok   = 1'b1;
                        e_ov   = 1'b1;
                        e_oj   = c_sel.slot_job[r_s];
                        e_last = !more && !higher;
                        n_any  = 1'b1;
                    end
                    if (r_s == W_SLOT'(JOBS_PER_WORKER - 1)) begin
                        // no jobs at all: one bare result for this worker
                        if (!cur_sv && !r_any) begin
                            emit   = 1'b1;
                            e_ok   = 1'b1;
                            e_last = !more;
                        end
                        cmd.op = C_KILL;
                        sel_en = 1'b1;
                        n_s    = '0;
                        n_any  = 1'b0;
                        if (more) n_w = r_w + W_IDX'(1);
                        else      n_state = S_IDLE;
                    end else begin
                        n_s = r_s + W_SLOT'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next    <= '0;
            r_dying   <= '0;
            r_w       <= '0;
            r_s       <= '0;
            r_any     <= 1'b0;
            r_acnt    <= '0;
            r_strobe  <= 1'b0;
            r_timeout <= TIMEOUT_RST;
        end else begin
            r_state  <= n_state;
            r_next   <= n_next;
            r_dying  <= n_dying;
            r_w      <= n_w;
            r_s      <= n_s;
            r_any    <= n_any;
            r_acnt   <= n_acnt;
            r_strobe <= emit;
            if (i_cfg_we) r_timeout <= i_cfg_data;
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_kind <= t_kind'(i_kind);
            r_tw   <= i_target_worker;
            r_rc   <= i_req_cpu;
            r_rm   <= i_req_mem;
            r_job  <= i_job_tag;
            r_exen <= i_exclude_enable;
            r_exw  <= i_exclude_worker;
            r_now  <= i_now_time;
        end
        if (emit) begin
            r_ok      <= e_ok;
            r_rw      <= e_rw;
            r_ov      <= e_ov;
            r_oj      <= e_oj;
            r_acpu    <= e_get ? t_sel.free_cpu : '0;
            r_amem    <= e_get ? t_sel.free_mem : '0;
            r_tcpu    <= e_get ? t_sel.cap_cpu  : '0;
            r_tmem    <= e_get ? t_sel.cap_mem  : '0;
            r_alive_o <= e_get && t_sel.alive;
            r_cnt     <= e_cnt;
            r_last    <= e_last;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_ok            = r_ok;
    assign o_result_worker = r_rw;
    assign o_orphan_valid  = r_ov;
    assign o_orphan_job    = r_oj;
    assign o_avail_cpu_out = r_acpu;
    assign o_avail_mem_out = r_amem;
    assign o_total_cpu_out = r_tcpu;
    assign o_total_mem_out = r_tmem;
    assign o_alive_out     = r_alive_o;
    assign o_live_workers  = r_cnt;
    assign o_last          = r_last;

    // checks
    `ASSERT_CLK(a_next_bound, r_next <= W_CNT'(MAX_WORKERS), "register index past table")
    `ASSERT_CLK(a_sweep_dying, (r_state != S_SWEEP) || (r_dying != '0), "sweep without dying set")
    `ASSERT_NEXT(a_search_done, (r_state == S_SEARCH) && tok[MAX_WORKERS].valid, r_strobe && r_last, "search result missing")
    `ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "accepted item not busy")

endmodule

[design/wrt_cell.sv]
// ----------------------------------------------------------------------------
// wrt_cell
// one worker entry with its job slots and one stage of the search chain
// ----------------------------------------------------------------------------
module wrt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [wrt_pkg::W_IDX-1:0] i_idx,
    input  logic                      i_sel,
    input  wrt_pkg::t_cell_cmd        i_cmd,
    input  logic [wrt_pkg::W_TIME-1:0] i_timeout,
    input  wrt_pkg::t_token           i_tok,
    output wrt_pkg::t_token           o_tok,
    output wrt_pkg::t_cell_stat       o_stat
);
    import wrt_pkg::*;

    logic                                  r_used, r_alive;
    logic [W_CPU-1:0]                      r_free_cpu, r_cap_cpu;
    logic [W_MEM-1:0]                      r_free_mem, r_cap_mem;
    logic [W_TIME-1:0]                     r_beat;
    logic [JOBS_PER_WORKER-1:0]            r_slot_valid;
    logic [JOBS_PER_WORKER-1:0][W_JOB-1:0] r_slot_job;
    t_token                                r_tok, n_tok;

    logic [JOBS_PER_WORKER-1:0] match;
    logic [W_SLOT-1:0]          match_slot, free_slot;
    logic [W_TIME-1:0]          age;
    logic [W_CPU:0]             sum_cpu;
    logic [W_MEM:0]             sum_mem;
    logic [W_CPU-1:0]           cand_cpu;
    logic [W_MEM-1:0]           cand_mem;
    logic                       cand;

    always_comb begin
        match_slot = '0;
        free_slot  = '0;
        for (int s = JOBS_PER_WORKER - 1; s >= 0; s--) begin
            match[s] = r_slot_valid[s] && (r_slot_job[s] == i_cmd.job);
            if (match[s]) match_slot = W_SLOT'(s);
            if (!r_slot_valid[s]) free_slot = W_SLOT'(s);
        end
    end

    assign age     = i_cmd.now - r_beat;
    assign sum_cpu = {1'b0, r_free_cpu} + {1'b0, i_cmd.cpu};
    assign sum_mem = {1'b0, r_free_mem} + {1'b0, i_cmd.mem};

    always_comb begin
        o_stat.used       = r_used;
        o_stat.alive      = r_alive;
        o_stat.stale      = age > i_timeout;
        o_stat.dup        = |match;
        o_stat.has_free   = ~&r_slot_valid;
        o_stat.free_cpu   = r_free_cpu;
        o_stat.free_mem   = r_free_mem;
        o_stat.cap_cpu    = r_cap_cpu;
        o_stat.cap_mem    = r_cap_mem;
        o_stat.slot_valid = r_slot_valid;
        o_stat.slot_job   = r_slot_job;
    end

    // search stage: test this entry, keep the best so far
    always_comb begin
        cand_cpu = i_tok.fit_mode ? r_free_cpu : r_cap_cpu;
        cand_mem = i_tok.fit_mode ? r_free_mem : r_cap_mem;
        cand = r_used && r_alive
            && !(i_tok.fit_mode && i_tok.exen && (i_tok.exw == i_idx))
            && (cand_cpu >= i_tok.req_cpu) && (cand_mem >= i_tok.req_mem);
        n_tok = i_tok;
        if (i_tok.valid && cand && (!i_tok.found || (cand_cpu > i_tok.best_cpu))) begin
            n_tok.found    = 1'b1;
            n_tok.best     = i_idx;
            n_tok.best_cpu = cand_cpu;
        end
    end

    assign o_tok = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= 1'b0;
            r_alive      <= 1'b0;
            r_slot_valid <= '0;
            r_tok        <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_sel) begin
                unique case (i_cmd.op)
                    C_REGISTER: begin
                        r_used       <= 1'b1;
                        r_alive      <= 1'b1;
                        r_slot_valid <= '0;
                    end
                    C_ALLOC:   r_slot_valid[free_slot]  <= 1'b1;
                    C_RELEASE: r_slot_valid[match_slot] <= 1'b0;
                    C_KILL: begin
                        r_alive      <= 1'b0;
                        r_slot_valid <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel) begin
            unique case (i_cmd.op)
                C_REGISTER: begin
                    r_free_cpu <= i_cmd.cpu;
                    r_cap_cpu  <= i_cmd.cpu;
                    r_free_mem <= i_cmd.mem;
                    r_cap_mem  <= i_cmd.mem;
                    r_beat     <= i_cmd.now;
                end
                C_BEAT: r_beat <= i_cmd.now;
                C_ALLOC: begin
                    r_slot_job[free_slot] <= i_cmd.job;
                    r_free_cpu <= r_free_cpu - i_cmd.cpu;
                    r_free_mem <= r_free_mem - i_cmd.mem;
                end
                C_RELEASE: begin
                    r_free_cpu <= (sum_cpu < {1'b0, r_cap_cpu}) ? sum_cpu[W_CPU-1:0]
                                                                : r_cap_cpu;
                    r_free_mem <= (sum_mem < {1'b0, r_cap_mem}) ? sum_mem[W_MEM-1:0]
                                                                : r_cap_mem;
                end
                C_KILL: begin
                    r_free_cpu <= '0;
                    r_free_mem <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

[bench/tb_worker_resource_table.sv]
// ----------------------------------------------------------------------------
// tb_worker_resource_table
// self-checking bench: a queue-fed driver sends table operations, an
// internal model of the worker table predicts every result, and a monitor
// compares each strobed result field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_worker_resource_table;
    import wrt_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [2:0]  tw;
        logic [15:0] cpu;
        logic [19:0] mem;
        logic [15:0] job;
        logic        exen;
        logic [2:0]  exw;
        logic [31:0] now;
    } t_op;

    typedef struct {
        logic        ok;
        logic [2:0]  worker;
        logic        ov;
        logic [15:0] job;
        logic [15:0] acpu;
        logic [19:0] amem;
        logic [15:0] tcpu;
        logic [19:0] tmem;
        logic        alive;
        logic [3:0]  count;
        logic        last;
    } t_res;

    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_kind = '0;
    logic [2:0]  i_target_worker = '0;
    logic [15:0] i_req_cpu = '0;
    logic [19:0] i_req_mem = '0;
    logic [15:0] i_job_tag = '0;
    logic        i_exclude_enable = 1'b0;
    logic [2:0]  i_exclude_worker = '0;
    logic [31:0] i_now_time = '0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy, o_strobe, o_ok, o_orphan_valid, o_alive_out, o_last;
    logic [2:0]  o_result_worker;
    logic [15:0] o_orphan_job, o_avail_cpu_out, o_total_cpu_out;
    logic [19:0] o_avail_mem_out, o_total_mem_out;
    logic [3:0]  o_live_workers;

    worker_resource_table dut (.*);

    // pending items, expected results, run statistics
    t_op  op_queue[$];
    t_res result_queue[$];
    int   errors = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   orphans_seen = 0;
    int   cycles = 0;
    bit   no_idle = 0;

    // shadow of the worker table
    bit          used[MAX_WORKERS];
    bit          alive[MAX_WORKERS];
    logic [15:0] free_cpu[MAX_WORKERS], cap_cpu[MAX_WORKERS];
    logic [19:0] free_mem[MAX_WORKERS], cap_mem[MAX_WORKERS];
    logic [31:0] beat[MAX_WORKERS];
    bit          slot_on[MAX_WORKERS][JOBS_PER_WORKER];
    logic [15:0] slot_tag[MAX_WORKERS][JOBS_PER_WORKER];
    int          next_free_row = 0;
    logic [31:0] timeout = TIMEOUT_RST;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res blank_res(logic ok, logic [2:0] w, logic ov, logic [15:0] j);
        t_res r;
        r = '{default: '0};
        r.ok = ok;
        r.worker = w;
        r.ov = ov;
        r.job = j;
        return r;
    endfunction

    function automatic int job_slot(int w, logic [15:0] j);
        for (int s = 0; s < JOBS_PER_WORKER; s++)
            if (slot_on[w][s] && slot_tag[w][s] == j) return s;
        return -1;
    endfunction

    // append one item to the pending queue
    function automatic void queue_op(t_op t);
        op_queue = {op_queue, t};
    endfunction

    // apply one operation to the shadow table and queue its results
    task automatic table_apply(t_op t);
        t_res out[$];
        int   w, s, n_alive;
        bit   found, any;
        logic [15:0] c, best_c;
        logic [19:0] m;
        logic [2:0]  best;
        logic [16:0] sum_c;
        logic [20:0] sum_m;
        w = t.tw;
        case (t.kind)
            K_REGISTER: begin
                if (next_free_row < MAX_WORKERS) begin
                    w = next_free_row;
                    used[w] = 1;
                    alive[w] = 1;
                    free_cpu[w] = t.cpu;
                    cap_cpu[w] = t.cpu;
                    free_mem[w] = t.mem;
                    cap_mem[w] = t.mem;
                    beat[w] = t.now;
                    for (s = 0; s < JOBS_PER_WORKER; s++) slot_on[w][s] = 0;
                    next_free_row++;
                    out = {out, blank_res(1, 3'(w), 0, 0)};
                end else begin
                    out = {out, blank_res(0, 0, 0, 0)};
                end
            end
            K_HEARTBEAT: begin
                found = used[w] && alive[w];
                if (found) beat[w] = t.now;
                out = {out, blank_res(found, 0, 0, 0)};
            end
            K_ALLOCATE: begin
                found = 0;
                if (used[w] && alive[w] && job_slot(w, t.job) < 0 &&
                    free_cpu[w] >= t.cpu && free_mem[w] >= t.mem) begin
                    for (s = 0; s < JOBS_PER_WORKER && !found; s++)
                        if (!slot_on[w][s]) begin
                            slot_on[w][s] = 1;
                            slot_tag[w][s] = t.job;
                            free_cpu[w] -= t.cpu;
                            free_mem[w] -= t.mem;
                            found = 1;
                        end
                end
                out = {out, blank_res(found, 0, 0, 0)};
            end
            K_RELEASE: begin
                found = 0;
                if (used[w] && alive[w]) begin
                    s = job_slot(w, t.job);
                    if (s >= 0) begin
                        // give back the request, never above the total
                        sum_c = free_cpu[w] + t.cpu;
                        sum_m = free_mem[w] + t.mem;
                        slot_on[w][s] = 0;
                        free_cpu[w] = (sum_c < cap_cpu[w]) ? sum_c[15:0] : cap_cpu[w];
                        free_mem[w] = (sum_m < cap_mem[w]) ? sum_m[19:0] : cap_mem[w];
                        found = 1;
                    end
                end
                out = {out, blank_res(found, 0, 0, 0)};
            end
            K_FIND_FIT, K_RESERVE: begin
                found = 0;
                best = 0;
                best_c = 0;
                for (int v = 0; v < MAX_WORKERS; v++) begin
                    if (!used[v] || !alive[v]) continue;
                    if (t.kind == K_FIND_FIT && t.exen && v == t.exw) continue;
                    c = (t.kind == K_FIND_FIT) ? free_cpu[v] : cap_cpu[v];
                    m = (t.kind == K_FIND_FIT) ? free_mem[v] : cap_mem[v];
                    if (c < t.cpu || m < t.mem) continue;
                    // strictly more cpu wins, so ties keep the lower index
                    if (!found || c > best_c) begin
                        found = 1;
                        best = 3'(v);
                        best_c = c;
                    end
                end
                out = {out, blank_res(found, found ? best : 3'd0, 0, 0)};
            end
            K_SWEEP: begin
                for (int v = 0; v < MAX_WORKERS; v++) begin
                    if (!used[v] || !alive[v]) continue;
                    // age is measured modulo 2^32
                    if (32'(t.now - beat[v]) <= timeout) continue;
                    alive[v] = 0;
                    free_cpu[v] = 0;
                    free_mem[v] = 0;
                    any = 0;
                    for (s = 0; s < JOBS_PER_WORKER; s++)
                        if (slot_on[v][s]) begin
                            out = {out, blank_res(1, 3'(v), 1, slot_tag[v][s])};
                            slot_on[v][s] = 0;
                            any = 1;
                        end
                    if (!any) out = {out, blank_res(1, 3'(v), 0, 0)};
                end
                if (out.size() == 0) out = {out, blank_res(0, 0, 0, 0)};
            end
            default: begin
                found = used[w];
                out = {out, blank_res(found, 0, 0, 0)};
                if (found) begin
                    out[0].acpu = free_cpu[w];
                    out[0].amem = free_mem[w];
                    out[0].tcpu = cap_cpu[w];
                    out[0].tmem = cap_mem[w];
                    out[0].alive = alive[w];
                end
            end
        endcase
        n_alive = 0;
        for (int v = 0; v < MAX_WORKERS; v++) n_alive += alive[v];
        foreach (out[k]) begin
            out[k].count = 4'(n_alive);
            out[k].last = (k == out.size() - 1);
            result_queue = {result_queue, out[k]};
        end
    endtask

    // driver: feeds the queue to the block, predicts at each accept edge
    t_op cur;
    int  gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                table_apply(cur);
                items_sent++;
                if (no_idle || $urandom_range(0, 3) == 0) gap = 0;
                else gap = $urandom_range(0, 13);
            end
            if (!i_start || !o_busy) begin
                if (gap > 0) begin
                    gap--;
                    i_start <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    cur = op_queue.pop_front();
                    i_kind <= cur.kind;
                    i_target_worker <= cur.tw;
                    i_req_cpu <= cur.cpu;
                    i_req_mem <= cur.mem;
                    i_job_tag <= cur.job;
                    i_exclude_enable <= cur.exen;
                    i_exclude_worker <= cur.exw;
                    i_now_time <= cur.now;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // monitor: every strobed result must match the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none actual ok=%0b worker=%0d",
                         $time, o_ok, o_result_worker);
                errors++;
            end else begin
                e = result_queue.pop_front();
                if (e.ov) orphans_seen++;
                check_field("ok", e.ok, o_ok);
                check_field("result_worker", e.worker, o_result_worker);
                check_field("orphan_valid", e.ov, o_orphan_valid);
                check_field("orphan_job", e.job, o_orphan_job);
                check_field("avail_cpu", e.acpu, o_avail_cpu_out);
                check_field("avail_mem", e.amem, o_avail_mem_out);
                check_field("total_cpu", e.tcpu, o_total_cpu_out);
                check_field("total_mem", e.tmem, o_total_mem_out);
                check_field("alive_out", e.alive, o_alive_out);
                check_field("live_workers", e.count, o_live_workers);
                check_field("last", e.last, o_last);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_op mk(t_kind k, int tw, int cpu, int mem, int job,
                               int exen, int exw, logic [31:0] now);
        t_op t;
        t.kind = k;
        t.tw = tw;
        t.cpu = cpu;
        t.mem = mem;
        t.job = job;
        t.exen = exen;
        t.exw = exw;
        t.now = now;
        return t;
    endfunction

    // random operation; small requests and a small tag pool keep hits likely
    function automatic t_op rand_op(logic [31:0] base, bit near);
        t_op t;
        int  r;
        r = $urandom_range(0, 99);
        if (r < 10) t.kind = K_HEARTBEAT;
        else if (r < 38) t.kind = K_ALLOCATE;
        else if (r < 58) t.kind = K_RELEASE;
        else if (r < 68) t.kind = K_FIND_FIT;
        else if (r < 75) t.kind = K_RESERVE;
        else if (r < 83) t.kind = K_SWEEP;
        else if (r < 93) t.kind = K_GET;
        else t.kind = K_REGISTER;
        t.tw = $urandom_range(0, 7);
        t.cpu = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 3000);
        t.mem = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20'hFFFFF)
                                            : $urandom_range(0, 40000);
        t.job = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 15);
        t.exen = $urandom_range(0, 1);
        t.exw = $urandom_range(0, 7);
        t.now = near ? base + $urandom_range(0, 3) : $urandom;
        return t;
    endfunction

    // let the queue drain and the block finish its longest sweep
    task automatic drain();
        while (op_queue.size() > 0 || i_start || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        timeout = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: registration extremes, get on an unused row, full table
        queue_op(mk(K_REGISTER, 0, 0, 0, 0, 0, 0, 0));
        queue_op(mk(K_REGISTER, 0, 65535, 20'hFFFFF, 0, 0, 0, 0));
        for (int i = 2; i < 7; i++)
            queue_op(mk(K_REGISTER, 0, 40000 + i, 500000, 0, 0, 0, 10));
        queue_op(mk(K_GET, 7, 0, 0, 0, 0, 0, 0));
        queue_op(mk(K_REGISTER, 0, 40000, 500000, 0, 0, 0, 20));
        queue_op(mk(K_REGISTER, 0, 1, 1, 0, 0, 0, 0));
        // allocate success, duplicate tag, short capacity, release clamped, tag missing
        queue_op(mk(K_ALLOCATE, 1, 100, 100, 5, 0, 0, 0));
        queue_op(mk(K_ALLOCATE, 1, 1, 1, 5, 0, 0, 0));
        queue_op(mk(K_ALLOCATE, 0, 1, 0, 6, 0, 0, 0));
        queue_op(mk(K_RELEASE, 1, 65535, 20'hFFFFF, 5, 0, 0, 0));
        queue_op(mk(K_RELEASE, 1, 0, 0, 9, 0, 0, 0));
        queue_op(mk(K_GET, 1, 0, 0, 0, 0, 0, 0));
        // slots full on the ninth job
        for (int i = 0; i < 9; i++)
            queue_op(mk(K_ALLOCATE, 3, 1, 1, 100 + i, 0, 0, 0));
        queue_op(mk(K_HEARTBEAT, 2, 0, 0, 0, 0, 0, 300));
        queue_op(mk(K_FIND_FIT, 0, 0, 0, 0, 1, 1, 0));
        queue_op(mk(K_FIND_FIT, 0, 0, 0, 0, 0, 1, 0));
        queue_op(mk(K_RESERVE, 0, 65535, 20'hFFFFF, 0, 0, 0, 0));
        queue_op(mk(K_SWEEP, 0, 0, 0, 0, 0, 0, 500));
        drain();

        // nobody can die with the largest timeout: exercise the accounting
        set_timeout(32'hFFFF_FFFF);
        for (int i = 0; i < 240; i++) begin
            no_idle = (i >= 100 && i < 140);
            queue_op(rand_op(0, 0));
        end
        drain();
        no_idle = 0;

        // mid timeout across the time wrap
        set_timeout(5000);
        queue_op(mk(K_HEARTBEAT, 2, 0, 0, 0, 0, 0, 32'hFFFF_F000));
        queue_op(mk(K_HEARTBEAT, 4, 0, 0, 0, 0, 0, 32'hFFFF_F000));
        queue_op(mk(K_SWEEP, 0, 0, 0, 0, 0, 0, 32'h0000_0100));
        for (int i = 0; i < 30; i++) queue_op(rand_op(32'hFFFF_FFFE, 1));
        drain();

        // zero timeout: any beat older than now kills the worker
        set_timeout(0);
        for (int i = 0; i < 60; i++) queue_op(rand_op(32'h0000_0010 + i, 1));
        queue_op(mk(K_SWEEP, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
        drain();

        $display("ran %0d items across timeouts 1000, max, 5000 and 0", items_sent);
        $display("checked %0d results, %0d of them orphaned jobs", results_seen,
                 orphans_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[worker_resource_table.f]
+incdir+design
design/wrt_pkg.sv
design/wrt_cell.sv
design/worker_resource_table.sv
bench/tb_worker_resource_table.sv
